// ===== hdl/ausf_pkg.sv =====
// shared types, constants and the second-byte fold table for the accent folder
// no dependencies
`timescale 1ns / 1ps

package ausf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SizeW = 16;

  localparam logic [ByteW-1:0] LEAD_BYTE    = 8'hC3;
  localparam logic [ByteW-1:0] NUL_BYTE     = 8'h00;
  localparam logic [ByteW-1:0] UPPER_FIRST  = 8'h41;
  localparam logic [ByteW-1:0] UPPER_LAST   = 8'h5A;
  localparam logic [ByteW-1:0] CASE_OFFSET  = 8'h20;
  localparam logic [SizeW-1:0] SIZE_RESET   = 16'd256;

  // second bytes after the lead byte, upper and lower case
  localparam logic [ByteW-1:0] A_ACUTE_UC = 8'h81;
  localparam logic [ByteW-1:0] A_ACUTE_LC = 8'hA1;
  localparam logic [ByteW-1:0] E_ACUTE_UC = 8'h89;
  localparam logic [ByteW-1:0] E_ACUTE_LC = 8'hA9;
  localparam logic [ByteW-1:0] I_ACUTE_UC = 8'h8D;
  localparam logic [ByteW-1:0] I_ACUTE_LC = 8'hAD;
  localparam logic [ByteW-1:0] O_ACUTE_UC = 8'h93;
  localparam logic [ByteW-1:0] O_ACUTE_LC = 8'hB3;
  localparam logic [ByteW-1:0] U_ACUTE_UC = 8'h9A;
  localparam logic [ByteW-1:0] U_ACUTE_LC = 8'hBA;
  localparam logic [ByteW-1:0] N_TILDE_UC = 8'h91;
  localparam logic [ByteW-1:0] N_TILDE_LC = 8'hB1;

  localparam logic [ByteW-1:0] CHAR_A = 8'h61;
  localparam logic [ByteW-1:0] CHAR_E = 8'h65;
  localparam logic [ByteW-1:0] CHAR_I = 8'h69;
  localparam logic [ByteW-1:0] CHAR_O = 8'h6F;
  localparam logic [ByteW-1:0] CHAR_U = 8'h75;
  localparam logic [ByteW-1:0] CHAR_N = 8'h6E;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  // plain letter for the byte after the lead byte, nul means drop
  function automatic logic [ByteW-1:0] fold_second(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] o;
    unique case (b)
      A_ACUTE_UC, A_ACUTE_LC: o = CHAR_A;
      E_ACUTE_UC, E_ACUTE_LC: o = CHAR_E;
      I_ACUTE_UC, I_ACUTE_LC: o = CHAR_I;
      O_ACUTE_UC, O_ACUTE_LC: o = CHAR_O;
      U_ACUTE_UC, U_ACUTE_LC: o = CHAR_U;
      N_TILDE_UC, N_TILDE_LC: o = CHAR_N;
      default:                o = NUL_BYTE;
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/utf8_spanish_accent_fold.sv =====
// top level of the utf-8 spanish accent folder: front, result queue, output stage
// depends on ausf_pkg, ausf_front, ausf_queue, ausf_back
//
//   channel   handshake                    payload
//   input     push_i / full_o              in_byte_i
//   result    pop_i / empty_o              out_byte_o, is_last_o
//   config    cfg_valid_i / cfg_ready_o    cfg_buffer_size_i
//
// one input item per cycle; the front folds a byte and updates the string
// state in the cycle it is accepted; results pass the queue and output register
// full_o rises only when the QDepth-entry queue is full, so result stalls reach
// the input after the queue and the output register have filled
// reset clears the string state and the queue and sets buffer_size to 256
`timescale 1ns / 1ps

module utf8_spanish_accent_fold #(
  parameter int unsigned QDepth = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [ausf_pkg::ByteW-1:0]  in_byte_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [ausf_pkg::ByteW-1:0]  out_byte_o,
  output logic                        is_last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ausf_pkg::SizeW-1:0]  cfg_buffer_size_i
);

  ausf_pkg::push_t    front_push;
  ausf_pkg::result_t  q_head;
  ausf_pkg::result_t  out_res;
  logic               q_full, q_empty, q_pop;
  logic               accept;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_full;
  assign accept      = push_i && !q_full;
  assign out_byte_o  = out_res.out_byte;
  assign is_last_o   = out_res.is_last;

  ausf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_buffer_size_i),
    .push_o      (front_push)
  );

  ausf_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  ausf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .res_o     (out_res)
  );

endmodule

// ===== hdl/ausf_front.sv =====
// front part: takes input bytes, classifies and folds them, keeps the string state
// and the buffer size register; depends on ausf_pkg
`timescale 1ns / 1ps

module ausf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ausf_pkg::ByteW-1:0]    in_byte_i,
  input  logic                          cfg_write_i,
  input  logic [ausf_pkg::SizeW-1:0]    cfg_data_i,
  output ausf_pkg::push_t               push_o
);

  logic                         lead_pending_q, lead_pending_d;
  logic [ausf_pkg::SizeW-1:0]   emitted_count_q, emitted_count_d;
  logic [ausf_pkg::SizeW-1:0]   buffer_size_q;
  logic [ausf_pkg::SizeW:0]     count_plus_one;
  logic                         at_limit;
  logic                         is_nul;
  logic                         emit;
  logic [ausf_pkg::ByteW-1:0]   fold_byte;

  // covers a zero buffer size as well
  assign count_plus_one = {1'b0, emitted_count_q} + {{ausf_pkg::SizeW{1'b0}}, 1'b1};
  assign at_limit       = count_plus_one >= {1'b0, buffer_size_q};
  assign is_nul         = in_byte_i == ausf_pkg::NUL_BYTE;

  always_comb begin
    lead_pending_d  = lead_pending_q;
    emitted_count_d = emitted_count_q;
    emit            = 1'b0;
    fold_byte       = ausf_pkg::NUL_BYTE;
    push_o          = '0;
    if (accept_i) begin
      if (is_nul) begin
        lead_pending_d = 1'b0;
        emitted_count_d = '0;
        push_o.valid = buffer_size_q != '0;
        push_o.res.out_byte = ausf_pkg::NUL_BYTE;
        push_o.res.is_last = 1'b1;
      end else if (!at_limit) begin
        if (lead_pending_q) begin
          lead_pending_d = 1'b0;
          fold_byte = ausf_pkg::fold_second(in_byte_i);
          emit = fold_byte != ausf_pkg::NUL_BYTE;
        end else if (!in_byte_i[ausf_pkg::ByteW-1]) begin
          if (in_byte_i >= ausf_pkg::UPPER_FIRST && in_byte_i <= ausf_pkg::UPPER_LAST) begin
            fold_byte = in_byte_i + ausf_pkg::CASE_OFFSET;
          end else begin
            fold_byte = in_byte_i;
          end
          emit = 1'b1;
        end else if (in_byte_i == ausf_pkg::LEAD_BYTE) begin
          lead_pending_d = 1'b1;
        end
        if (emit) begin
          emitted_count_d = count_plus_one[ausf_pkg::SizeW-1:0];
          push_o.valid = 1'b1;
          push_o.res.out_byte = fold_byte;
          push_o.res.is_last = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q  <= 1'b0;
      emitted_count_q <= '0;
      buffer_size_q   <= ausf_pkg::SIZE_RESET;
    end else begin
      lead_pending_q  <= lead_pending_d;
      emitted_count_q <= emitted_count_d;
      if (cfg_write_i) begin
        buffer_size_q <= cfg_data_i;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a terminator clears the string state
  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_nul |=> !lead_pending_q && emitted_count_q == '0)
    else $error("string state not cleared after nul");

  // the terminator always carries a zero byte, folded bytes never do
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> (push_o.res.is_last == (push_o.res.out_byte == ausf_pkg::NUL_BYTE)))
    else $error("terminator flag and byte disagree");

  // nothing but a terminator leaves the front once the output limit is reached
  a_limit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !is_nul && at_limit |-> !push_o.valid && emitted_count_d == emitted_count_q)
    else $error("item emitted past the output limit");
`endif

endmodule

// ===== hdl/ausf_queue.sv =====
// short result queue between the front and the output stage
// depends on ausf_pkg for the entry type
`timescale 1ns / 1ps

module ausf_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ausf_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output ausf_pkg::result_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ausf_pkg::result_t  mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign full_o  = count_q == DepthC;
  assign empty_o = count_q == '0;
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/ausf_back.sv =====
// back part: output register that drains the queue and holds a result until popped
// depends on ausf_pkg for the result type
`timescale 1ns / 1ps

module ausf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  ausf_pkg::result_t q_head_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ausf_pkg::result_t res_o
);

  logic              valid_q;
  ausf_pkg::result_t res_q;

  // refill whenever the register is free or is being taken this cycle
  assign q_pop_o = !q_empty_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule
